[hdl/ccu_pkg.sv]
// Package with the types, codes, tables and helpers of the CORDIC unit.
`default_nettype none
package ccu_pkg;

   localparam int MAX_ITERATIONS = 32;
   localparam int IDX_W          = 5;
   localparam int CNT_W          = 6;
   localparam int DATA_W         = 32;
   localparam int XY_W           = 40;

   localparam logic [CNT_W-1:0] ITER_RESET = 6'd32;
   localparam logic [CNT_W-1:0] ITER_MAX   = 6'd32;

   localparam logic [1:0] CMD_CIRC_ROT = 2'd0;
   localparam logic [1:0] CMD_CIRC_VEC = 2'd1;
   localparam logic [1:0] CMD_HYP_ROT  = 2'd2;
   localparam logic [1:0] CMD_HYP_VEC  = 2'd3;

   localparam logic [IDX_W-1:0] REPEAT_A = 5'd3;
   localparam logic [IDX_W-1:0] REPEAT_B = 5'd12;

   localparam logic signed [DATA_W-1:0] LIM_HALF_PI = 32'sd421657428;
   localparam logic signed [DATA_W-1:0] LIM_HYP     = 32'sd297963356;

   typedef struct packed {
      logic             load;
      logic             advance;
      logic [1:0]       cmd;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] gain_idx;
   } step_ctrl_type;

   typedef struct packed {
      logic       idle;
      logic       finish;
      logic [1:0] cmd;
      logic       err;
   } seq_status_type;

   function automatic logic is_repeat(input logic [IDX_W-1:0] idx);
      return (idx == REPEAT_A) || (idx == REPEAT_B);
   endfunction

   function automatic logic signed [DATA_W-1:0] atan_q(input logic [IDX_W-1:0] idx);
      logic signed [DATA_W-1:0] v;
      v = '0;
      unique case (idx)
         5'd0:  v = 32'sd210828714;
         5'd1:  v = 32'sd124459457;
         5'd2:  v = 32'sd65760959;
         5'd3:  v = 32'sd33381290;
         5'd4:  v = 32'sd16755422;
         5'd5:  v = 32'sd8385879;
         5'd6:  v = 32'sd4193963;
         5'd7:  v = 32'sd2097109;
         5'd8:  v = 32'sd1048571;
         5'd9:  v = 32'sd524287;
         5'd29: v = 32'sd1;
         5'd30: v = 32'sd0;
         5'd31: v = 32'sd0;
         default: v = $signed(32'd1 << (5'd28 - idx));
      endcase
      return v;
   endfunction

   function automatic logic signed [DATA_W-1:0] atanh_q(input logic [IDX_W-1:0] idx);
      logic signed [DATA_W-1:0] v;
      v = '0;
      unique case (idx)
         5'd0:  v = 32'sd147453245;
         5'd1:  v = 32'sd68561855;
         5'd2:  v = 32'sd33730852;
         5'd3:  v = 32'sd16799113;
         5'd4:  v = 32'sd8391340;
         5'd5:  v = 32'sd4194645;
         5'd6:  v = 32'sd2097195;
         5'd7:  v = 32'sd1048581;
         5'd8:  v = 32'sd524289;
         5'd28: v = 32'sd1;
         5'd29: v = 32'sd0;
         5'd30: v = 32'sd0;
         5'd31: v = 32'sd0;
         default: v = $signed(32'd1 << (5'd27 - idx));
      endcase
      return v;
   endfunction

   function automatic logic signed [DATA_W-1:0] gain_c_q(input logic [IDX_W-1:0] idx);
      logic signed [DATA_W-1:0] v;
      v = '0;
      unique case (idx)
         5'd0:  v = 32'sd189812531;
         5'd1:  v = 32'sd169773489;
         5'd2:  v = 32'sd164704477;
         5'd3:  v = 32'sd163432609;
         5'd4:  v = 32'sd163114337;
         5'd5:  v = 32'sd163034749;
         5'd6:  v = 32'sd163014851;
         5'd7:  v = 32'sd163009877;
         5'd8:  v = 32'sd163008633;
         5'd9:  v = 32'sd163008322;
         5'd10: v = 32'sd163008244;
         5'd11: v = 32'sd163008225;
         5'd12: v = 32'sd163008220;
         default: v = 32'sd163008219;
      endcase
      return v;
   endfunction

   function automatic logic signed [DATA_W-1:0] gain_h_q(input logic [IDX_W-1:0] idx);
      logic signed [DATA_W-1:0] v;
      v = '0;
      unique case (idx)
         5'd0:  v = 32'sd309962566;
         5'd1:  v = 32'sd320127961;
         5'd2:  v = 32'sd322658656;
         5'd3:  v = 32'sd323923984;
         5'd4:  v = 32'sd324082266;
         5'd5:  v = 32'sd324121834;
         5'd6:  v = 32'sd324131726;
         5'd7:  v = 32'sd324134199;
         5'd8:  v = 32'sd324134818;
         5'd9:  v = 32'sd324134972;
         5'd10: v = 32'sd324135011;
         5'd11: v = 32'sd324135020;
         5'd12: v = 32'sd324135025;
         default: v = 32'sd324135026;
      endcase
      return v;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [XY_W:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > $signed({{(XY_W-30){1'b0}}, {31{1'b1}}})) begin
         r = {1'b0, {31{1'b1}}};
      end else if (v < $signed({{(XY_W-30){1'b1}}, {31{1'b0}}})) begin
         r = {1'b1, {31{1'b0}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/ccu_if.sv]
// Handshake interfaces for the request, response and register write channels.
`default_nettype none
interface ccu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic signed [31:0] first_operand;
   logic signed [31:0] second_operand;
   modport source (output valid, cmd, first_operand, second_operand, input ready);
   modport sink   (input valid, cmd, first_operand, second_operand, output ready);
endinterface

interface ccu_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] x_result;
   logic signed [31:0] y_result;
   logic signed [31:0] angle_result;
   logic signed [31:0] exp_result;
   logic        range_error;
   modport source (output valid, x_result, y_result, angle_result, exp_result, range_error,
                   input ready);
   modport sink   (input valid, x_result, y_result, angle_result, exp_result, range_error,
                   output ready);
endinterface

interface ccu_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[hdl/ccu_rotator.sv]
// Shift-add datapath holding x, y and z, one micro-rotation per advance.
`default_nettype none
module ccu_rotator (
   input  logic                                 clock,
   input  ccu_pkg::step_ctrl_type               ctrl,
   input  logic signed [ccu_pkg::DATA_W-1:0]    first_operand,
   input  logic signed [ccu_pkg::DATA_W-1:0]    second_operand,
   output logic signed [ccu_pkg::XY_W-1:0]      x_value,
   output logic signed [ccu_pkg::XY_W-1:0]      y_value,
   output logic signed [ccu_pkg::XY_W-1:0]      z_value
);
   localparam int XW = ccu_pkg::XY_W;
   localparam int DW = ccu_pkg::DATA_W;

   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [DW-1:0] target_ff, target_in;
   logic [ccu_pkg::CNT_W-1:0] shift_amt;
   logic signed [XW-1:0] x_sh, y_sh, ang_ext, target_ext, gain_ext;
   logic signed [DW-1:0] ang, gain;
   logic sigma, add_x, add_y;

   always_comb begin
      shift_amt  = ctrl.cmd[1] ? ({1'b0, ctrl.idx} + 6'd1) : {1'b0, ctrl.idx};
      x_sh       = x_ff >>> shift_amt;
      y_sh       = y_ff >>> shift_amt;
      ang        = ctrl.cmd[1] ? ccu_pkg::atanh_q(ctrl.idx) : ccu_pkg::atan_q(ctrl.idx);
      ang_ext    = {{(XW-DW){ang[DW-1]}}, ang};
      target_ext = {{(XW-DW){target_ff[DW-1]}}, target_ff};
      sigma      = ctrl.cmd[0] ? (y_ff > 0) : (target_ext > z_ff);
      add_x      = ((ctrl.cmd == ccu_pkg::CMD_CIRC_ROT) || (ctrl.cmd == ccu_pkg::CMD_HYP_VEC))
                   ? !sigma : sigma;
      add_y      = ctrl.cmd[0] ? !sigma : sigma;
      gain       = ctrl.cmd[1] ? ccu_pkg::gain_h_q(ctrl.gain_idx)
                               : ccu_pkg::gain_c_q(ctrl.gain_idx);
      gain_ext   = {{(XW-DW){gain[DW-1]}}, gain};

      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      target_in = target_ff;
      if (ctrl.load) begin
         target_in = first_operand;
         z_in      = '0;
         if (ctrl.cmd[0]) begin
            x_in = {{(XW-DW){second_operand[DW-1]}}, second_operand};
            y_in = {{(XW-DW){first_operand[DW-1]}}, first_operand};
         end else begin
            x_in = gain_ext;
            y_in = '0;
         end
      end else if (ctrl.advance) begin
         x_in = add_x ? (x_ff + y_sh) : (x_ff - y_sh);
         y_in = add_y ? (y_ff + x_sh) : (y_ff - x_sh);
         z_in = sigma ? (z_ff + ang_ext) : (z_ff - ang_ext);
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      target_ff <= target_in;
   end

   assign x_value = x_ff;
   assign y_value = y_ff;
   assign z_value = z_ff;
endmodule
`default_nettype wire

[hdl/ccu_sequencer.sv]
// Iteration sequencer that counts micro-rotations and hyperbolic repeats.
`default_nettype none
module ccu_sequencer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [1:0]                   start_cmd,
   input  logic                         start_err,
   input  logic [ccu_pkg::IDX_W-1:0]    last_index,
   input  logic                         out_free,
   output ccu_pkg::step_ctrl_type       ctrl,
   output ccu_pkg::seq_status_type      status
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [ccu_pkg::IDX_W-1:0] i_ff, i_in, last_ff, last_in;
   logic rep_ff, rep_in;
   logic [1:0] cmd_ff, cmd_in;
   logic err_ff, err_in;
   logic rep_pending;

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      last_in     = last_ff;
      rep_in      = rep_ff;
      cmd_in      = cmd_ff;
      err_in      = err_ff;
      rep_pending = cmd_ff[1] && ccu_pkg::is_repeat(i_ff) && !rep_ff;

      ctrl.load     = 1'b0;
      ctrl.advance  = 1'b0;
      ctrl.cmd      = cmd_ff;
      ctrl.idx      = i_ff;
      ctrl.gain_idx = last_index;
      status.idle   = 1'b0;
      status.finish = 1'b0;
      status.cmd    = cmd_ff;
      status.err    = err_ff;

      unique case (state_ff)
         S_IDLE: begin
            status.idle = 1'b1;
            ctrl.cmd    = start_cmd;
            if (start) begin
               ctrl.load = 1'b1;
               cmd_in    = start_cmd;
               err_in    = start_err;
               last_in   = last_index;
               i_in      = '0;
               rep_in    = 1'b0;
               state_in  = start_err ? S_DONE : S_RUN;
            end
         end
         S_RUN: begin
            ctrl.advance = 1'b1;
            if (rep_pending) begin
               rep_in = 1'b1;
            end else if (i_ff == last_ff) begin
               state_in = S_DONE;
            end else begin
               i_in   = i_ff + 5'd1;
               rep_in = 1'b0;
            end
         end
         S_DONE: begin
            status.finish = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff    <= i_in;
      last_ff <= last_in;
      rep_ff  <= rep_in;
      cmd_ff  <= cmd_in;
      err_ff  <= err_in;
   end
endmodule
`default_nettype wire

[hdl/cordic_circular_hyperbolic_unit_core.sv]
// Top level of the circular and hyperbolic CORDIC unit.
//
//   channel   direction  payload                                       transfer
//   req_bus   in         cmd, first_operand, second_operand            valid & ready
//   rsp_bus   out        x, y, angle, exp results and range_error      valid & ready
//   csr_bus   in         iteration count (6 bits)                      valid & ready
//
// A transaction runs one micro-rotation for each of its n iterations, plus a repeated
// micro-rotation for each hyperbolic repeat reached (iterations 3 and 12), all on the
// single shift-add rotator. A transaction that fails its range check skips them.
// Reset is synchronous and sets the iteration count to 32.
// A result waits in the output register while the next transaction is taken in; the
// rotator stalls at its end until that register is free.
`default_nettype none
module cordic_circular_hyperbolic_unit_core (
   input  logic       clock,
   input  logic       reset,
   ccu_req_if.sink    req_bus,
   ccu_rsp_if.source  rsp_bus,
   ccu_csr_if.sink    csr_bus
);
   localparam int XW = ccu_pkg::XY_W;
   localparam int DW = ccu_pkg::DATA_W;

   logic [ccu_pkg::CNT_W-1:0] iter_ff, iter_in;
   logic [ccu_pkg::CNT_W-1:0] last_wide;
   logic [ccu_pkg::IDX_W-1:0] last_index;
   logic start, start_err, out_free;
   logic signed [DW-1:0] a, b;
   ccu_pkg::step_ctrl_type  ctrl;
   ccu_pkg::seq_status_type status;
   logic signed [XW-1:0] x_value, y_value, z_value;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] x_ff, x_in, y_ff, y_in, ang_ff, ang_in, exp_ff, exp_in;
   logic err_ff, err_in;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = status.idle;
   assign start         = req_bus.valid && status.idle;
   assign a             = req_bus.first_operand;
   assign b             = req_bus.second_operand;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      iter_in = csr_bus.valid ? csr_bus.data : iter_ff;
      if (iter_ff == '0) begin
         last_wide = '0;
      end else if (iter_ff > ccu_pkg::ITER_MAX) begin
         last_wide = ccu_pkg::ITER_MAX - 6'd1;
      end else begin
         last_wide = iter_ff - 6'd1;
      end
      last_index = last_wide[ccu_pkg::IDX_W-1:0];

      unique case (req_bus.cmd)
         ccu_pkg::CMD_CIRC_ROT: start_err = (a < 0) || (a > ccu_pkg::LIM_HALF_PI);
         ccu_pkg::CMD_CIRC_VEC: start_err = (b < 0) || (a < 0) || (a > b);
         ccu_pkg::CMD_HYP_ROT:  start_err = (a > ccu_pkg::LIM_HYP) || (a < -ccu_pkg::LIM_HYP);
         ccu_pkg::CMD_HYP_VEC:  start_err = (b < 0) || (a < 0);
         default:               start_err = 1'b1;
      endcase
   end

   ccu_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_cmd  (req_bus.cmd),
      .start_err  (start_err),
      .last_index (last_index),
      .out_free   (out_free),
      .ctrl       (ctrl),
      .status     (status)
   );

   ccu_rotator u_rot (
      .clock          (clock),
      .ctrl           (ctrl),
      .first_operand  (a),
      .second_operand (b),
      .x_value        (x_value),
      .y_value        (y_value),
      .z_value        (z_value)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      x_in   = x_ff;
      y_in   = y_ff;
      ang_in = ang_ff;
      exp_in = exp_ff;
      err_in = err_ff;
      if (status.finish) begin
         rsp_valid_in = 1'b1;
         err_in       = status.err;
         if (status.err) begin
            x_in   = '0;
            y_in   = '0;
            ang_in = '0;
            exp_in = '0;
         end else begin
            x_in   = ccu_pkg::sat32({x_value[XW-1], x_value});
            y_in   = ccu_pkg::sat32({y_value[XW-1], y_value});
            ang_in = status.cmd[0] ? ccu_pkg::sat32({z_value[XW-1], z_value}) : '0;
            exp_in = (status.cmd == ccu_pkg::CMD_HYP_ROT)
                     ? ccu_pkg::sat32({x_value[XW-1], x_value} + {y_value[XW-1], y_value})
                     : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff      <= ccu_pkg::ITER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      ang_ff <= ang_in;
      exp_ff <= exp_in;
      err_ff <= err_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.x_result     = x_ff;
   assign rsp_bus.y_result     = y_ff;
   assign rsp_bus.angle_result = ang_ff;
   assign rsp_bus.exp_result   = exp_ff;
   assign rsp_bus.range_error  = err_ff;
endmodule
`default_nettype wire

[hdl/ccu_checker.sv]
// Port-level checker for the CORDIC unit and its bind to the top level.
`default_nettype none
module ccu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] x_result,
   input logic [31:0] y_result,
   input logic [31:0] angle_result,
   input logic [31:0] exp_result,
   input logic        range_error
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(x_result) && $stable(exp_result))
      else $error("response changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && range_error |-> x_result == 0 && y_result == 0 &&
                                   angle_result == 0 && exp_result == 0)
      else $error("range error with nonzero results");

   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while busy");

   a_exp_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && exp_result != 0 |-> angle_result == 0)
      else $error("exp and angle both set");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind cordic_circular_hyperbolic_unit_core ccu_checker u_ccu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .x_result     (rsp_bus.x_result),
   .y_result     (rsp_bus.y_result),
   .angle_result (rsp_bus.angle_result),
   .exp_result   (rsp_bus.exp_result),
   .range_error  (rsp_bus.range_error)
);
`default_nettype wire

[tb/sv/tb_cordic_circular_hyperbolic_unit_core.sv]
// Self-checking testbench of the circular and hyperbolic CORDIC unit.
`default_nettype none
module tb_cordic_circular_hyperbolic_unit_core;

   typedef struct {
      logic signed [31:0] x_val;
      logic signed [31:0] y_val;
      logic signed [31:0] angle_val;
      logic signed [31:0] exp_val;
      logic               range_err;
   } cordic_result_type;

   typedef struct {
      logic [1:0]         cmd;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic               err_known;
   } stim_row_type;

   localparam int DRAIN_CYCLES = 48;
   localparam int STALL_LIMIT  = 3000;

   logic clock;
   logic reset;
   int   error_count;
   int   stall_cycles;
   logic burst_send;
   logic burst_recv;
   logic [5:0] iter_setting;

   longint atan_rom [ccu_pkg::MAX_ITERATIONS];
   longint atanh_rom [ccu_pkg::MAX_ITERATIONS];
   longint gain_circ_rom [ccu_pkg::MAX_ITERATIONS];
   longint gain_hyp_rom [ccu_pkg::MAX_ITERATIONS];
   longint half_pi_limit;
   longint hyp_limit;

   cordic_result_type pending_results[$];

   ccu_req_if req_bus ();
   ccu_rsp_if rsp_bus ();
   ccu_csr_if csr_bus ();

   cordic_circular_hyperbolic_unit_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #6 clock = ~clock;

   function automatic longint unsigned q60_mul(longint unsigned a, longint unsigned b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   function automatic longint unsigned arc_sum(int unsigned s, bit alternate);
      longint unsigned acc;
      longint unsigned term;
      int unsigned m;
      bit neg;
      acc = 0;
      neg = 0;
      for (m = 1; s * m <= 60; m += 2) begin
         term = (64'd1 << (60 - s * m)) / m;
         acc = neg ? acc - term : acc + term;
         if (alternate) neg = !neg;
      end
      return acc;
   endfunction

   function automatic longint unsigned gain_term(int unsigned s, bit alternate);
      longint unsigned f;
      longint unsigned term;
      int unsigned k;
      bit neg;
      f = 64'd1 << 60;
      term = f;
      neg = alternate;
      if (2 * s > 60) return f;
      for (k = 1; k < 64; k++) begin
         term = ((term >> (2 * s)) * (2 * k - 1)) / (2 * k);
         if (term == 0) break;
         f = neg ? f - term : f + term;
         if (alternate) neg = !neg;
      end
      return f;
   endfunction

   function automatic longint round_q28(longint unsigned v);
      return longint'((v + (64'd1 << 31)) >> 32);
   endfunction

   function automatic bit repeat_step(int unsigned i);
      return i == 3 || i == 12 || i == 39 || i == 120;
   endfunction

   task automatic build_tables();
      longint unsigned gc;
      longint unsigned gh;
      longint unsigned pi_quarter;
      int unsigned i;
      pi_quarter = 64'h0C90FDAA22168C23;
      gc = 64'd1 << 60;
      gh = 64'd1 << 60;
      for (i = 0; i < ccu_pkg::MAX_ITERATIONS; i++) begin
         atan_rom[i] = round_q28(i == 0 ? pi_quarter : arc_sum(i, 1));
         atanh_rom[i] = round_q28(arc_sum(i + 1, 0));
         gc = q60_mul(gc, i == 0 ? 64'h0B504F333F9DE648 : gain_term(i, 1));
         gain_circ_rom[i] = round_q28(gc);
         gh = q60_mul(gh, gain_term(i + 1, 0));
         if (repeat_step(i)) gh = q60_mul(gh, gain_term(i + 1, 0));
         gain_hyp_rom[i] = round_q28(gh);
      end
      half_pi_limit = longint'((pi_quarter << 1) >> 32);
      hyp_limit = longint'((64'd111 << 28) / 100);
   endtask

   function automatic longint shift_floor(longint v, int unsigned s);
      if (s > 63) s = 63;
      return v >>> s;
   endfunction

   function automatic logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic cordic_result_type cordic_predict(logic [1:0] cmd,
                                                        logic signed [31:0] a_in,
                                                        logic signed [31:0] b_in);
      cordic_result_type r;
      longint a, x, y, z, xt, ang, ex;
      int unsigned n, i, rep;
      bit err;
      a = a_in;
      x = 0; y = 0; z = 0; ang = 0; ex = 0;
      err = 0;
      n = 32'(iter_setting);
      if (n == 0) n = 1;
      if (n > ccu_pkg::MAX_ITERATIONS) n = ccu_pkg::MAX_ITERATIONS;
      case (cmd)
         ccu_pkg::CMD_CIRC_ROT: begin
            if (a < 0 || a > half_pi_limit) err = 1;
            else begin
               x = gain_circ_rom[n - 1];
               for (i = 0; i < n; i++) begin
                  xt = x;
                  if (a > z) begin
                     x -= shift_floor(y, i); y += shift_floor(xt, i); z += atan_rom[i];
                  end else begin
                     x += shift_floor(y, i); y -= shift_floor(xt, i); z -= atan_rom[i];
                  end
               end
            end
         end
         ccu_pkg::CMD_CIRC_VEC: begin
            y = a; x = b_in;
            if (x < 0 || y < 0 || y > x) err = 1;
            else begin
               for (i = 0; i < n; i++) begin
                  xt = x;
                  if (y > 0) begin
                     x += shift_floor(y, i); y -= shift_floor(xt, i); z += atan_rom[i];
                  end else begin
                     x -= shift_floor(y, i); y += shift_floor(xt, i); z -= atan_rom[i];
                  end
               end
               ang = z;
            end
         end
         ccu_pkg::CMD_HYP_ROT: begin
            if (a > hyp_limit || a < -hyp_limit) err = 1;
            else begin
               x = gain_hyp_rom[n - 1];
               for (i = 0; i < n; i++) begin
                  for (rep = repeat_step(i) ? 2 : 1; rep > 0; rep--) begin
                     xt = x;
                     if (a > z) begin
                        x += shift_floor(y, i + 1); y += shift_floor(xt, i + 1);
                        z += atanh_rom[i];
                     end else begin
                        x -= shift_floor(y, i + 1); y -= shift_floor(xt, i + 1);
                        z -= atanh_rom[i];
                     end
                  end
               end
               ex = x + y;
            end
         end
         default: begin
            y = a; x = b_in;
            if (x < 0 || y < 0) err = 1;
            else begin
               for (i = 0; i < n; i++) begin
                  for (rep = repeat_step(i) ? 2 : 1; rep > 0; rep--) begin
                     xt = x;
                     if (y > 0) begin
                        x -= shift_floor(y, i + 1); y -= shift_floor(xt, i + 1);
                        z += atanh_rom[i];
                     end else begin
                        x += shift_floor(y, i + 1); y += shift_floor(xt, i + 1);
                        z -= atanh_rom[i];
                     end
                  end
               end
               ang = z;
            end
         end
      endcase
      if (err) begin
         x = 0; y = 0; ang = 0; ex = 0;
      end
      r.x_val = clip32(x);
      r.y_val = clip32(y);
      r.angle_val = clip32(ang);
      r.exp_val = clip32(ex);
      r.range_err = err;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic send_request(logic [1:0] cmd, logic signed [31:0] a, logic signed [31:0] b,
                               bit err_known);
      int gap;
      cordic_result_type r;
      gap = burst_send ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.first_operand <= a;
      req_bus.second_operand <= b;
      do @(posedge clock); while (!req_bus.ready);
      if (err_known) begin
         r = '{x_val: 0, y_val: 0, angle_val: 0, exp_val: 0, range_err: 1'b1};
      end else begin
         r = cordic_predict(cmd, a, b);
      end
      pending_results.push_back(r);
   endtask

   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
   endtask

   task automatic write_iterations(logic [5:0] value);
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      iter_setting = value;
   endtask

   task automatic send_random();
      logic [1:0] cmd;
      logic signed [31:0] a, b;
      int unsigned xs;
      cmd = 2'($urandom_range(0, 3));
      a = $urandom();
      b = $urandom();
      if ($urandom_range(0, 9) >= 2) begin
         xs = $urandom_range(0, 32'h7FFFFFFF);
         case (cmd)
            ccu_pkg::CMD_CIRC_ROT: a = $urandom_range(0, 32'(half_pi_limit));
            ccu_pkg::CMD_HYP_ROT:
               a = $urandom_range(0, 32'(2 * hyp_limit)) - 32'(hyp_limit);
            default: begin
               if ($urandom_range(0, 3) == 0) xs = xs >> $urandom_range(0, 30);
               b = xs;
               a = $urandom_range(0, xs);
            end
         endcase
      end
      send_request(cmd, a, b, 1'b0);
   endtask

   stim_row_type directed_rows[] = '{
      '{ccu_pkg::CMD_CIRC_ROT, -32'sd1, 32'sd0, 1'b1},
      '{ccu_pkg::CMD_CIRC_ROT, ccu_pkg::LIM_HALF_PI + 32'sd1, 32'sd0, 1'b1},
      '{ccu_pkg::CMD_CIRC_ROT, 32'sh7FFFFFFF, 32'sh80000000, 1'b1},
      '{ccu_pkg::CMD_CIRC_ROT, 32'sd0, 32'sh7FFFFFFF, 1'b0},
      '{ccu_pkg::CMD_CIRC_ROT, ccu_pkg::LIM_HALF_PI, 32'sd0, 1'b0},
      '{ccu_pkg::CMD_CIRC_VEC, 32'sd0, -32'sd1, 1'b1},
      '{ccu_pkg::CMD_CIRC_VEC, -32'sd1, 32'sd100, 1'b1},
      '{ccu_pkg::CMD_CIRC_VEC, 32'sd101, 32'sd100, 1'b1},
      '{ccu_pkg::CMD_CIRC_VEC, 32'sd0, 32'sd0, 1'b0},
      '{ccu_pkg::CMD_CIRC_VEC, 32'sd0, 32'sh7FFFFFFF, 1'b0},
      '{ccu_pkg::CMD_CIRC_VEC, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0},
      '{ccu_pkg::CMD_HYP_ROT, ccu_pkg::LIM_HYP + 32'sd1, 32'sd0, 1'b1},
      '{ccu_pkg::CMD_HYP_ROT, -ccu_pkg::LIM_HYP - 32'sd1, 32'sd0, 1'b1},
      '{ccu_pkg::CMD_HYP_ROT, 32'sh80000000, 32'sd0, 1'b1},
      '{ccu_pkg::CMD_HYP_ROT, ccu_pkg::LIM_HYP, 32'sd0, 1'b0},
      '{ccu_pkg::CMD_HYP_ROT, -ccu_pkg::LIM_HYP, 32'sd0, 1'b0},
      '{ccu_pkg::CMD_HYP_ROT, 32'sd0, 32'sd0, 1'b0},
      '{ccu_pkg::CMD_HYP_VEC, 32'sd5, -32'sd1, 1'b1},
      '{ccu_pkg::CMD_HYP_VEC, 32'sh80000000, 32'sd5, 1'b1},
      '{ccu_pkg::CMD_HYP_VEC, 32'sd0, 32'sd0, 1'b0},
      '{ccu_pkg::CMD_HYP_VEC, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0},
      '{ccu_pkg::CMD_HYP_VEC, 32'sd1000, 32'sh7FFFFFFF, 1'b0}
   };

   logic [5:0] iteration_plan[] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd5, 6'd13, 6'd4, 6'd32};

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      error_count = 0;
      burst_send = 1'b0;
      iter_setting = ccu_pkg::ITER_RESET;
      req_bus.valid = 1'b0;
      req_bus.cmd = ccu_pkg::CMD_CIRC_ROT;
      req_bus.first_operand = '0;
      req_bus.second_operand = '0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      build_tables();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[k]) begin
         send_request(directed_rows[k].cmd, directed_rows[k].a, directed_rows[k].b,
                      directed_rows[k].err_known);
      end
      foreach (iteration_plan[p]) begin
         write_iterations(iteration_plan[p]);
         for (int k = 0; k < 190; k++) begin
            if (k % 40 == 0) burst_send = ($urandom_range(0, 3) == 0);
            if (p == 2 && k == 95) wait_results_drained();
            send_random();
         end
      end
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int hold;
      hold = 0;
      burst_recv = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 63) == 0) burst_recv = !burst_recv;
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_bus.valid && rsp_bus.ready) begin
            hold = burst_recv ? 0 : $urandom_range(0, 19);
            rsp_bus.ready <= (hold == 0);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cordic_result_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with none expected");
         end else begin
            e = pending_results.pop_front();
            if (rsp_bus.x_result !== e.x_val)
               report_mismatch($sformatf("x %0d, want %0d", rsp_bus.x_result, e.x_val));
            if (rsp_bus.y_result !== e.y_val)
               report_mismatch($sformatf("y %0d, want %0d", rsp_bus.y_result, e.y_val));
            if (rsp_bus.angle_result !== e.angle_val)
               report_mismatch($sformatf("angle %0d, want %0d", rsp_bus.angle_result,
                                         e.angle_val));
            if (rsp_bus.exp_result !== e.exp_val)
               report_mismatch($sformatf("exp %0d, want %0d", rsp_bus.exp_result, e.exp_val));
            if (rsp_bus.range_error !== e.range_err)
               report_mismatch($sformatf("range_error %0b, want %0b", rsp_bus.range_error,
                                         e.range_err));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial stall_cycles = 0;

endmodule
`default_nettype wire
